[src/rbqs_pkg.sv]
// shared types, constants and tables of the read base quality statistics block
package rbqs_pkg;

    localparam int QUAL_BINS     = 256;
    localparam int MAX_READ_BITS = 28;
    localparam int COUNTER_BITS  = 48;
    localparam int GC_BINS       = 101;
    localparam int N_TOTALS      = 7;

    localparam int ADDR_W    = 10;
    localparam int RAM_AW    = ADDR_W + 1;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int CLR_W     = RAM_AW + 1;

    localparam int BQ_BASE  = 0;
    localparam int RQ_BASE  = QUAL_BINS;
    localparam int GC_BASE  = 2 * QUAL_BINS;
    localparam int TOT_BASE = GC_BASE + GC_BINS;
    localparam int MAP_END  = TOT_BASE + N_TOTALS;

    localparam int TOT_READS = 0;
    localparam int TOT_BASES = 1;
    localparam int TOT_A     = 2;
    localparam int TOT_C     = 3;
    localparam int TOT_G     = 4;
    localparam int TOT_T     = 5;
    localparam int TOT_N     = 6;

    localparam logic [3:0] CODE_A = 4'd1;
    localparam logic [3:0] CODE_C = 4'd2;
    localparam logic [3:0] CODE_G = 4'd4;
    localparam logic [3:0] CODE_T = 4'd8;
    localparam logic [3:0] CODE_N = 4'd15;

    localparam logic ACT_BASE    = 1'b0;
    localparam logic ACT_READOUT = 1'b1;
    localparam logic RK_SUMMARY  = 1'b0;
    localparam logic RK_READOUT  = 1'b1;

    localparam int DIV_W     = 64;
    localparam int DVS_W     = MAX_READ_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int GC_MAX    = 100;

    typedef struct packed {
        logic                     action;
        logic [3:0]               base_code;
        logic [7:0]               qual_byte;
        logic                     last_base;
        logic                     primary;
        logic                     stats_set;
        logic [ADDR_W-1:0]        counter_addr;
    } in_t;

    typedef struct packed {
        logic                     result_kind;
        logic [MAX_READ_BITS-1:0] base_count;
        logic [7:0]               mean_phred;
        logic [6:0]               gc_percent;
        logic                     gc_valid;
        logic                     qual_overflow;
        logic [COUNTER_BITS-1:0]  counter_value;
    } out_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RO_RD, ST_RO_EMIT,
        ST_BQ_RD, ST_BQ_WR, ST_TB_RD, ST_TB_WR, ST_TC_RD, ST_TC_WR,
        ST_MEAN_GO, ST_MEAN_RUN, ST_SRCH_INIT, ST_SRCH, ST_GC_GO, ST_GC_RUN,
        ST_TR_RD, ST_TR_WR, ST_RQ_RD, ST_RQ_WR, ST_GH_RD, ST_GH_WR, ST_SUM_EMIT
    } state_t;

    typedef enum logic [2:0] {
        AS_CLEAR, AS_BQ, AS_TB, AS_TC, AS_TR, AS_RQ, AS_GH, AS_RO
    } addr_sel_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      ram_rd;
        logic      ram_wr;
        logic      clr_step;
        logic      capture;
        logic      acc;
        logic      div_mean;
        logic      div_gc;
        logic      srch_init;
        logic      srch_step;
        logic      emit_ro;
        logic      emit_sum;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_readout;
        logic last;
        logic primary;
        logic code_counted;
        logic div_busy;
        logic srch_last;
        logic ovf;
        logic gcv;
        logic out_full;
    } status_t;

    typedef logic [32:0] tab_t [256];

    localparam longint unsigned ROOT_TAB [20] = '{
        64'd1000000000, 64'd891250938, 64'd794328235, 64'd707945784, 64'd630957344,
        64'd562341325, 64'd501187234, 64'd446683592, 64'd398107171, 64'd354813389,
        64'd316227766, 64'd281838293, 64'd251188643, 64'd223872114, 64'd199526231,
        64'd177827941, 64'd158489319, 64'd141253754, 64'd125892541, 64'd112201845
    };

    // num never exceeds den, so the integer quotient is 0 or 1
    function automatic longint unsigned fix32(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned x;
        if (num >= den) begin
            q = 64'd1;
            x = num - den;
        end else begin
            q = 64'd0;
            x = num;
        end
        for (int b = 0; b < 33; b++) begin
            x = x << 1;
            q = q << 1;
            if (x >= den) begin
                x = x - den;
                q = q | 64'd1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    function automatic longint unsigned table_value(int unsigned j);
        longint unsigned den;
        int unsigned     r;
        int unsigned     i;
        den = 64'd1000000000;
        r   = j;
        i   = 0;
        for (int unsigned n = 0; n < 26; n++) begin
            if (r >= 20) begin
                r = r - 20;
                i = i + 1;
            end
        end
        if (i >= 10) begin
            return 64'd0;
        end
        for (int unsigned n = 0; n < i; n++) begin
            den = den * 64'd10;
        end
        return fix32(ROOT_TAB[r], den);
    endfunction

    function automatic tab_t build_tab(bit thr);
        tab_t t;
        for (int k = 0; k < 256; k++) begin
            if (!thr) begin
                t[k] = 33'(table_value(2 * k));
            end else if (k == 0) begin
                t[k] = '0;
            end else begin
                t[k] = 33'(table_value(2 * k - 1));
            end
        end
        return t;
    endfunction

    localparam tab_t PROB_TAB = build_tab(1'b0);
    localparam tab_t THR_TAB  = build_tab(1'b1);

endpackage

[src/rbqs_ram.sv]
// generic single write port, registered read ram
module rbqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/rbqs_dp.sv]
// datapath: counter memory, per-read accumulators, divider, threshold search, result register
module rbqs_dp
    import rbqs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    cmd,
    output status_t st,
    input  in_t     s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output out_t    m_data
);

    in_t                      in_reg;
    logic [MAX_READ_BITS-1:0] len_reg, gc_reg, acgt_reg;
    logic [63:0]              psum_reg;
    logic [CLR_W-1:0]         clr_reg;
    logic [DIV_W-1:0]         q_reg;
    logic [DVS_W-1:0]         r_reg, d_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic                     busy_reg;
    logic [7:0]               p_reg;
    logic [2:0]               idx_reg;
    logic                     m_valid_reg;
    out_t                     m_data_reg;

    logic [COUNTER_BITS-1:0]  rdata;
    logic [RAM_AW-1:0]        ram_addr;
    logic [ADDR_W-1:0]        a10;
    logic [7:0]               bq_bin;
    logic [2:0]               tc_idx;
    logic                     code_counted;
    logic                     is_gc;
    logic [6:0]               gcp;
    logic [64:0]              psum_add;
    logic [DVS_W:0]           trial;
    logic                     ge;
    logic [7:0]               cand;
    logic [36:0]              gc_dividend;
    logic                     ovf;
    logic                     gcv;

    localparam logic [MAX_READ_BITS-1:0] LEN_MAX = '1;

    assign bq_bin = ({1'b0, in_reg.qual_byte} < 9'(QUAL_BINS)) ?
                    in_reg.qual_byte : 8'(QUAL_BINS - 1);

    always_comb begin
        tc_idx       = 3'(TOT_N);
        code_counted = 1'b1;
        is_gc        = 1'b0;
        unique case (in_reg.base_code)
            CODE_A:  tc_idx = 3'(TOT_A);
            CODE_C:  begin tc_idx = 3'(TOT_C); is_gc = 1'b1; end
            CODE_G:  begin tc_idx = 3'(TOT_G); is_gc = 1'b1; end
            CODE_T:  tc_idx = 3'(TOT_T);
            CODE_N:  tc_idx = 3'(TOT_N);
            default: code_counted = 1'b0;
        endcase
    end

    assign gcp  = (q_reg > 64'(GC_MAX)) ? 7'(GC_MAX) : q_reg[6:0];
    assign ovf  = ({1'b0, p_reg} >= 9'(QUAL_BINS));
    assign gcv  = (acgt_reg != '0);

    always_comb begin
        unique case (cmd.addr_sel)
            AS_BQ:    a10 = ADDR_W'(BQ_BASE) + ADDR_W'(bq_bin);
            AS_TB:    a10 = ADDR_W'(TOT_BASE + TOT_BASES);
            AS_TC:    a10 = ADDR_W'(TOT_BASE) + ADDR_W'(tc_idx);
            AS_TR:    a10 = ADDR_W'(TOT_BASE + TOT_READS);
            AS_RQ:    a10 = ADDR_W'(RQ_BASE) + ADDR_W'(p_reg);
            AS_GH:    a10 = ADDR_W'(GC_BASE) + ADDR_W'(gcp);
            AS_RO:    a10 = in_reg.counter_addr;
            default:  a10 = '0;
        endcase
        ram_addr = (cmd.addr_sel == AS_CLEAR) ? clr_reg[RAM_AW-1:0] : {in_reg.stats_set, a10};
    end

    rbqs_ram #(.WIDTH(COUNTER_BITS), .DEPTH(RAM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (cmd.ram_wr),
        .waddr (ram_addr),
        .wdata ((cmd.addr_sel == AS_CLEAR) ? '0 : rdata + COUNTER_BITS'(1)),
        .re    (cmd.ram_rd),
        .raddr (ram_addr),
        .rdata (rdata)
    );

    // shared restoring divider, one quotient bit per cycle
    assign trial = {r_reg, q_reg[DIV_W-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign gc_dividend = (37'(gc_reg) << 7) + (37'(gc_reg) << 6) + (37'(gc_reg) << 3)
                       + 37'(acgt_reg);
    assign psum_add = {1'b0, psum_reg} + 65'(PROB_TAB[in_reg.qual_byte]);
    assign cand = p_reg | (8'd1 << idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.div_mean) begin
            q_reg <= psum_reg;
            d_reg <= DVS_W'(len_reg);
            r_reg <= '0;
        end else if (cmd.div_gc) begin
            q_reg <= DIV_W'(gc_dividend);
            d_reg <= {acgt_reg, 1'b0};
            r_reg <= '0;
        end else if (busy_reg) begin
            q_reg <= {q_reg[DIV_W-2:0], ge};
            r_reg <= ge ? DVS_W'(trial - {1'b0, d_reg}) : trial[DVS_W-1:0];
        end
        if (cmd.srch_init) begin
            p_reg   <= '0;
            idx_reg <= 3'd7;
        end else if (cmd.srch_step) begin
            idx_reg <= idx_reg - 3'd1;
            if (q_reg <= 64'(THR_TAB[cand])) begin
                p_reg <= cand;
            end
        end
        if (cmd.emit_ro) begin
            m_data_reg.result_kind   <= RK_READOUT;
            m_data_reg.base_count    <= '0;
            m_data_reg.mean_phred    <= '0;
            m_data_reg.gc_percent    <= '0;
            m_data_reg.gc_valid      <= 1'b0;
            m_data_reg.qual_overflow <= 1'b0;
            m_data_reg.counter_value <= (in_reg.counter_addr < ADDR_W'(MAP_END)) ? rdata : '0;
        end else if (cmd.emit_sum) begin
            m_data_reg.result_kind   <= RK_SUMMARY;
            m_data_reg.base_count    <= len_reg;
            m_data_reg.mean_phred    <= p_reg;
            m_data_reg.gc_percent    <= gcv ? gcp : '0;
            m_data_reg.gc_valid      <= gcv;
            m_data_reg.qual_overflow <= ovf;
            m_data_reg.counter_value <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            gc_reg      <= '0;
            acgt_reg    <= '0;
            psum_reg    <= '0;
            clr_reg     <= '0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (cmd.div_mean || cmd.div_gc) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
            if (cmd.acc) begin
                if (len_reg != LEN_MAX) len_reg <= len_reg + MAX_READ_BITS'(1);
                if (code_counted && (tc_idx != 3'(TOT_N)) && acgt_reg != LEN_MAX) begin
                    acgt_reg <= acgt_reg + MAX_READ_BITS'(1);
                end
                if (is_gc && gc_reg != LEN_MAX) gc_reg <= gc_reg + MAX_READ_BITS'(1);
                psum_reg <= psum_add[64] ? '1 : psum_add[63:0];
            end else if (cmd.emit_sum) begin
                len_reg  <= '0;
                gc_reg   <= '0;
                acgt_reg <= '0;
                psum_reg <= '0;
            end
            if (cmd.emit_ro || cmd.emit_sum) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign st.clr_done     = clr_reg[CLR_W-1];
    assign st.in_readout   = (s_data.action == ACT_READOUT);
    assign st.last         = in_reg.last_base;
    assign st.primary      = in_reg.primary;
    assign st.code_counted = code_counted;
    assign st.div_busy     = busy_reg;
    assign st.srch_last    = (idx_reg == 3'd0);
    assign st.ovf          = ovf;
    assign st.gcv          = gcv;
    assign st.out_full     = m_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/rbqs_ctrl.sv]
// controller state machine sequencing counter updates and end-of-read work
module rbqs_ctrl
    import rbqs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (st.clr_done) state_next = ST_IDLE;
            ST_IDLE:      if (s_valid) state_next = st.in_readout ? ST_RO_RD : ST_BQ_RD;
            ST_RO_RD:     state_next = ST_RO_EMIT;
            ST_RO_EMIT:   if (!st.out_full) state_next = ST_IDLE;
            ST_BQ_RD:     state_next = ST_BQ_WR;
            ST_BQ_WR:     state_next = ST_TB_RD;
            ST_TB_RD:     state_next = ST_TB_WR;
            ST_TB_WR: begin
                priority if (st.code_counted) state_next = ST_TC_RD;
                else if (st.last)             state_next = ST_MEAN_GO;
                else                          state_next = ST_IDLE;
            end
            ST_TC_RD:     state_next = ST_TC_WR;
            ST_TC_WR:     state_next = st.last ? ST_MEAN_GO : ST_IDLE;
            ST_MEAN_GO:   state_next = ST_MEAN_RUN;
            ST_MEAN_RUN:  if (!st.div_busy) state_next = ST_SRCH_INIT;
            ST_SRCH_INIT: state_next = ST_SRCH;
            ST_SRCH:      if (st.srch_last) state_next = ST_GC_GO;
            ST_GC_GO:     state_next = ST_GC_RUN;
            ST_GC_RUN:    if (!st.div_busy) state_next = ST_TR_RD;
            ST_TR_RD:     state_next = ST_TR_WR;
            ST_TR_WR: begin
                priority if (!st.ovf)             state_next = ST_RQ_RD;
                else if (st.gcv && st.primary)    state_next = ST_GH_RD;
                else                              state_next = ST_SUM_EMIT;
            end
            ST_RQ_RD:     state_next = ST_RQ_WR;
            ST_RQ_WR:     state_next = (st.gcv && st.primary) ? ST_GH_RD : ST_SUM_EMIT;
            ST_GH_RD:     state_next = ST_GH_WR;
            ST_GH_WR:     state_next = ST_SUM_EMIT;
            ST_SUM_EMIT:  if (!st.out_full) state_next = ST_IDLE;
            default:      state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.addr_sel = AS_CLEAR;
                cmd.ram_wr   = !st.clr_done;
                cmd.clr_step = !st.clr_done;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_RO_RD:     begin cmd.addr_sel = AS_RO; cmd.ram_rd = 1'b1; end
            ST_RO_EMIT:   cmd.emit_ro = !st.out_full;
            ST_BQ_RD:     begin cmd.addr_sel = AS_BQ; cmd.ram_rd = 1'b1; cmd.acc = 1'b1; end
            ST_BQ_WR:     begin cmd.addr_sel = AS_BQ; cmd.ram_wr = 1'b1; end
            ST_TB_RD:     begin cmd.addr_sel = AS_TB; cmd.ram_rd = 1'b1; end
            ST_TB_WR:     begin cmd.addr_sel = AS_TB; cmd.ram_wr = 1'b1; end
            ST_TC_RD:     begin cmd.addr_sel = AS_TC; cmd.ram_rd = 1'b1; end
            ST_TC_WR:     begin cmd.addr_sel = AS_TC; cmd.ram_wr = 1'b1; end
            ST_MEAN_GO:   cmd.div_mean = 1'b1;
            ST_MEAN_RUN:  cmd.addr_sel = AS_CLEAR;
            ST_SRCH_INIT: cmd.srch_init = 1'b1;
            ST_SRCH:      cmd.srch_step = 1'b1;
            ST_GC_GO:     cmd.div_gc = 1'b1;
            ST_GC_RUN:    cmd.addr_sel = AS_CLEAR;
            ST_TR_RD:     begin cmd.addr_sel = AS_TR; cmd.ram_rd = 1'b1; end
            ST_TR_WR:     begin cmd.addr_sel = AS_TR; cmd.ram_wr = 1'b1; end
            ST_RQ_RD:     begin cmd.addr_sel = AS_RQ; cmd.ram_rd = 1'b1; end
            ST_RQ_WR:     begin cmd.addr_sel = AS_RQ; cmd.ram_wr = 1'b1; end
            ST_GH_RD:     begin cmd.addr_sel = AS_GH; cmd.ram_rd = 1'b1; end
            ST_GH_WR:     begin cmd.addr_sel = AS_GH; cmd.ram_wr = 1'b1; end
            ST_SUM_EMIT:  cmd.emit_sum = !st.out_full;
            default:      cmd = '0;
        endcase
    end

endmodule

[src/read_base_quality_stats.sv]
// top level of the read base quality and gc statistics block
// A base transfer updates two counters, or three when its code is A, C, G, T or N; each
// counter is a read-modify-write of the single counter memory. The last base of a read adds
// two passes of the shared bit-serial divider (mean error probability, gc percent), an 8-step
// threshold search and up to three more counter updates. After reset a clearing pass zeroes
// the counter memory; no input transfer is taken until it ends. A result waiting in the output
// register does not keep the next base from being accepted.
module read_base_quality_stats
    import rbqs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t    cmd;
    status_t st;

    rbqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    rbqs_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !st.clr_done |-> !s_ready)
        else $error("input accepted during clearing pass");

    a_gc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RK_SUMMARY) |-> (m_data.gc_percent <= 7'(GC_MAX)))
        else $error("gc percent out of range");

    a_gc_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RK_SUMMARY && !m_data.gc_valid)
        |-> (m_data.gc_percent == '0))
        else $error("gc percent set without gc bases");

    a_readout_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RK_READOUT)
        |-> (m_data.base_count == '0 && m_data.mean_phred == '0 && !m_data.gc_valid))
        else $error("readout carries summary fields");

    a_summary_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RK_SUMMARY) |-> (m_data.base_count != '0))
        else $error("summary for empty read");

endmodule
